[design/fm32_pkg.sv]
package fm32_pkg;

    localparam int unsigned FracBits = 23;
    localparam int unsigned ExpBits  = 8;
    localparam int unsigned MantBits = FracBits + 1;
    localparam int unsigned ProdBits = 2 * MantBits;

    localparam logic [9:0] ExpBias = 10'd127;
    localparam logic [9:0] ExpMax  = 10'd255;
    localparam logic [FracBits-1:0] FracOnes = '1;

    typedef struct packed {
        logic                a_sign;
        logic [ExpBits-1:0]  a_exponent;
        logic [FracBits-1:0] a_fraction;
        logic                b_sign;
        logic [ExpBits-1:0]  b_exponent;
        logic [FracBits-1:0] b_fraction;
    } t_fm32_in;

    typedef struct packed {
        logic                product_sign;
        logic [ExpBits-1:0]  product_exponent;
        logic [FracBits-1:0] product_fraction;
        logic                overflow_flag;
        logic                underflow_flag;
    } t_fm32_out;

endpackage

[design/float32_multiplier.sv]
// Channel  | Ports                         | Handshake
// ---------+-------------------------------+----------------------------------
// operands | i_start, o_busy, i_operands   | taken when i_start and !o_busy
// product  | o_done, o_product             | o_done high one cycle, no stall
//
// Four register stages: input capture, 24x24 multiply, normalize and
// exponent check, output. o_done rises with the output stage, in step with o_product.
// A new transaction is taken every cycle; o_busy is always low since the
// receiver cannot stall. Reset clears the valid bits only.
module float32_multiplier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  fm32_pkg::t_fm32_in i_operands,
    output logic               o_done,
    output fm32_pkg::t_fm32_out o_product
);

    localparam int unsigned FB = fm32_pkg::FracBits;
    localparam int unsigned PB = fm32_pkg::ProdBits;

    logic [3:0] r_vld;
    logic [3:0] n_vld;

    // stage 1: capture
    fm32_pkg::t_fm32_in r_s1;

    // stage 2: product and raw exponent
    logic [PB-1:0] r_s2_prod;
    logic [9:0]    r_s2_exp;
    logic          r_s2_sign;
    logic          r_s2_zero;

    // stage 3: normalized
    logic [FB-1:0] r_s3_frac;
    logic [9:0]    r_s3_exp;
    logic          r_s3_sign;
    logic          r_s3_zero;

    fm32_pkg::t_fm32_out r_out;
    fm32_pkg::t_fm32_out n_out;

    logic [PB-1:0] n_prod;
    logic [9:0]    n_exp2;
    logic [FB-1:0] n_frac3;
    logic [9:0]    n_exp3;

    assign n_vld = {r_vld[2:0], i_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign n_prod = PB'({1'b1, r_s1.a_fraction}) * PB'({1'b1, r_s1.b_fraction});
    assign n_exp2 = {2'b00, r_s1.a_exponent} + {2'b00, r_s1.b_exponent};

    always_comb begin
        // top product bit set: take the wider shift and bump the exponent
        if (r_s2_prod[PB-1]) begin
            n_frac3 = r_s2_prod[PB-2 -: FB];
            n_exp3  = r_s2_exp + 10'd1;
        end else begin
            n_frac3 = r_s2_prod[PB-3 -: FB];
            n_exp3  = r_s2_exp;
        end
    end

    always_comb begin
        n_out = '0;
        if (!r_s3_zero) begin
            // exponent still carries the bias: >= 255+127 overflows, <= 127 underflows
            if (r_s3_exp >= fm32_pkg::ExpMax + fm32_pkg::ExpBias) begin
                n_out.product_sign     = r_s3_sign;
                n_out.product_exponent = fm32_pkg::ExpMax[7:0];
                n_out.product_fraction = fm32_pkg::FracOnes;
                n_out.overflow_flag    = 1'b1;
            end else if (r_s3_exp <= fm32_pkg::ExpBias) begin
                n_out.underflow_flag = 1'b1;
            end else begin
                n_out.product_sign     = r_s3_sign;
                n_out.product_exponent = 8'(r_s3_exp - fm32_pkg::ExpBias);
                n_out.product_fraction = r_s3_frac;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1      <= i_operands;
        r_s2_prod <= n_prod;
        r_s2_exp  <= n_exp2;
        r_s2_sign <= r_s1.a_sign ^ r_s1.b_sign;
        r_s2_zero <= (r_s1.a_exponent == '0) || (r_s1.b_exponent == '0);
        r_s3_frac <= n_frac3;
        r_s3_exp  <= n_exp3;
        r_s3_sign <= r_s2_sign;
        r_s3_zero <= r_s2_zero;
        r_out     <= n_out;
    end

    assign o_busy    = 1'b0;
    assign o_done    = r_vld[3];
    assign o_product = r_out;

endmodule
